/* src/vfa_pkg.sv */
// Shared types, constants and step functions for the Q16.16 vector ALU.
// Used by the square-root pipe, the divider pipe and the top level.
package vfa_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;                // component width
    localparam int PW        = 64;                // product width
    localparam int WW        = PW + 2;            // sum of three products
    localparam int EPS_W     = 17;
    localparam int SQ_STEPS  = PW / 2;            // one root bit per stage
    localparam int DIV_STEPS = PW;                // one quotient bit per stage
    localparam int DIV_DW    = PW - FRAC_BITS;    // widest divisor (cosine)
    localparam int NMUL      = 9;

    localparam logic [3:0] CMD_ADD   = 4'd0;
    localparam logic [3:0] CMD_SUB   = 4'd1;
    localparam logic [3:0] CMD_SCALE = 4'd2;
    localparam logic [3:0] CMD_DOT   = 4'd3;
    localparam logic [3:0] CMD_CROSS = 4'd4;
    localparam logic [3:0] CMD_LEN   = 4'd5;
    localparam logic [3:0] CMD_NORM  = 4'd6;
    localparam logic [3:0] CMD_COS   = 4'd7;
    localparam logic [3:0] CMD_CMP   = 4'd8;

    localparam logic signed [WW-1:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [WW-1:0] SAT_MIN = -66'sd2147483648;
    localparam logic [PW-1:0] MAG_POS_MAX = 64'h0000_0000_7FFF_FFFF;
    localparam logic [PW-1:0] MAG_NEG_MAX = 64'h0000_0000_8000_0000;

    typedef struct packed {
        logic [DW-1:0] val;
        logic          flt;
    } sat_t;

    typedef struct packed {
        logic [PW-1:0] n;
        logic [PW-1:0] r;
    } sq_t;

    typedef struct packed {
        logic [DIV_DW-1:0] rem;
        logic [PW-1:0]     num;
        logic [PW-1:0]     q;
        logic [DIV_DW-1:0] d;
    } div_t;

    // Sideband that rides alongside the root and divide pipes
    typedef struct packed {
        logic [3:0]          cmd;
        logic [2:0][DW-1:0]  ev;      // early vector result
        logic [DW-1:0]       esc;     // early scalar result
        logic                eq;
        logic                eflt;
        logic [2:0]          neg;     // signs of A for normalise
        logic                dneg;    // sign of dot for cosine
        logic [2:0][PW-1:0]  num;     // dividends
        logic [DW-1:0]       len_a;
        logic                p_zero;
    } side_t;

    function automatic sat_t sat_wide(logic signed [WW-1:0] v);
        sat_t res;
        res.flt = 1'b0;
        res.val = v[DW-1:0];
        if (v > SAT_MAX)
        begin
            res.val = SAT_MAX[DW-1:0];
            res.flt = 1'b1;
        end
        else if (v < SAT_MIN)
        begin
            res.val = SAT_MIN[DW-1:0];
            res.flt = 1'b1;
        end
        return res;
    endfunction

    function automatic sat_t signed_mag(logic neg, logic [PW-1:0] mag);
        sat_t          res;
        logic [PW-1:0] negm;
        negm    = '0 - mag;
        res.flt = 1'b0;
        if (neg)
        begin
            res.val = negm[DW-1:0];
            if (mag > MAG_NEG_MAX)
            begin
                res.val = MAG_NEG_MAX[DW-1:0];
                res.flt = 1'b1;
            end
        end
        else
        begin
            res.val = mag[DW-1:0];
            if (mag > MAG_POS_MAX)
            begin
                res.val = MAG_POS_MAX[DW-1:0];
                res.flt = 1'b1;
            end
        end
        return res;
    endfunction

    // One digit-by-digit root step; stage k tests bit 4^(SQ_STEPS-1-k)
    function automatic sq_t sqrt_step(sq_t cur, int k);
        logic [PW-1:0] bitv;
        logic [PW:0]   trial;
        sq_t           res;
        bitv  = PW'(1) << (PW - 2 - 2 * k);
        trial = {1'b0, cur.r} + {1'b0, bitv};
        if ({1'b0, cur.n} >= trial)
        begin
            res.n = cur.n - trial[PW-1:0];
            res.r = (cur.r >> 1) + bitv;
        end
        else
        begin
            res.n = cur.n;
            res.r = cur.r >> 1;
        end
        return res;
    endfunction

    // One restoring division step, dividend consumed from its top bit
    function automatic div_t div_step(div_t cur);
        logic [DIV_DW:0] sh;
        logic [DIV_DW:0] diff;
        div_t            res;
        sh      = {cur.rem, cur.num[PW-1]};
        diff    = sh - {1'b0, cur.d};
        res     = cur;
        res.num = cur.num << 1;
        if (sh >= {1'b0, cur.d})
        begin
            res.rem = diff[DIV_DW-1:0];
            res.q   = {cur.q[PW-2:0], 1'b1};
        end
        else
        begin
            res.rem = sh[DIV_DW-1:0];
            res.q   = {cur.q[PW-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

/* src/vector3_fixed_point_alu_core.sv */
// Top level of the three-component Q16.16 vector ALU.
// Depends on vfa_pkg, vfa_sqrt_pipe and vfa_div_pipe.

// Fully pipelined vector unit: one beat can enter every clock cycle while
// the pipe is not halted, and every command passes through all of its
// stages alike. The pipe is built from the 32-stage square-root
// pipe (one root bit per stage) followed by the 64-stage divider
// (one quotient bit per stage); four front stages form operands,
// products, sums and the early results, one stage multiplies the
// two lengths and a final register holds the result beat. The whole pipe
// advances together: it halts only when the result register is full and the
// sink is not ready, so s_tready is low exactly then. Results are saturated
// to 32 bits with fault set; a cosine whose length product is zero gives 0
// with fault set, normalising a zero vector gives a zero vector.
// compare_epsilon is written on the cfg channel (always ready, resets to 1)
// and must only change while no beat is in flight.
module vector3_fixed_point_alu_core (
    input  logic         clk,
    input  logic         rst_n,
    // cfg_data: compare_epsilon [16:0]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [16:0]  cfg_data,
    // s_tdata from bit 0: cmd[3:0], a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
    // zero padding [231:228]
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [231:0] s_tdata,
    // m_tdata from bit 0: out_x, out_y, out_z, out_scalar, is_equal, fault,
    // zero padding [135:130]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata
);

    localparam int DW       = vfa_pkg::DW;
    localparam int PW       = vfa_pkg::PW;
    localparam int WW       = vfa_pkg::WW;
    localparam int FB       = vfa_pkg::FRAC_BITS;
    localparam int CMD_W    = 4;
    localparam int A_LSB    = CMD_W;
    localparam int B_LSB    = CMD_W + 3 * DW;
    localparam int S_LSB    = CMD_W + 6 * DW;
    localparam int OUT_BITS = 4 * DW + 2;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    logic adv;

    // compare tolerance
    logic [vfa_pkg::EPS_W-1:0] eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= vfa_pkg::EPS_W'(1);
        else if (cfg_valid && cfg_ready)
            eps_reg <= cfg_data;
    end

    assign cfg_ready = 1'b1;

    // whole pipe moves when the result register is free or being drained
    logic vout_reg;
    assign adv      = !vout_reg || m_tready;
    assign s_tready = adv;

    // ---- stage 0: capture, choose multiplier operands -----------------
    logic [CMD_W-1:0]       in_cmd;
    logic signed [DW-1:0]   in_a [3];
    logic signed [DW-1:0]   in_b [3];
    logic signed [DW-1:0]   in_s;
    logic signed [DW-1:0]   opl_next [vfa_pkg::NMUL];
    logic signed [DW-1:0]   opr_next [vfa_pkg::NMUL];
    logic signed [DW-1:0]   opl_reg  [vfa_pkg::NMUL];
    logic signed [DW-1:0]   opr_reg  [vfa_pkg::NMUL];
    logic [CMD_W-1:0]       cmd0_reg, cmd1_reg, cmd2_reg;
    logic signed [DW-1:0]   a0_reg [3];
    logic signed [DW-1:0]   b0_reg [3];
    logic signed [DW-1:0]   a1_reg [3];
    logic signed [DW-1:0]   b1_reg [3];
    logic signed [DW-1:0]   a2_reg [3];
    logic signed [DW-1:0]   b2_reg [3];
    logic                   v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;

    always_comb
    begin
        logic is_cross;
        logic is_scale;
        in_cmd = s_tdata[CMD_W-1:0];
        for (int i = 0; i < 3; i++)
        begin
            in_a[i] = s_tdata[A_LSB + DW * i +: DW];
            in_b[i] = s_tdata[B_LSB + DW * i +: DW];
        end
        in_s     = s_tdata[S_LSB +: DW];
        is_cross = (in_cmd == vfa_pkg::CMD_CROSS);
        is_scale = (in_cmd == vfa_pkg::CMD_SCALE);
        // lanes 0-2: dot terms or scale; 3-5: |A|^2 or first cross terms;
        // 6-8: |B|^2 or second cross terms
        for (int i = 0; i < 3; i++)
        begin
            opl_next[i] = in_a[i];
            opr_next[i] = is_scale ? in_s : in_b[i];
        end
        opl_next[3] = is_cross ? in_a[1] : in_a[0];
        opr_next[3] = is_cross ? in_b[2] : in_a[0];
        opl_next[4] = is_cross ? in_a[2] : in_a[1];
        opr_next[4] = is_cross ? in_b[0] : in_a[1];
        opl_next[5] = is_cross ? in_a[0] : in_a[2];
        opr_next[5] = is_cross ? in_b[1] : in_a[2];
        opl_next[6] = is_cross ? in_a[2] : in_b[0];
        opr_next[6] = is_cross ? in_b[1] : in_b[0];
        opl_next[7] = is_cross ? in_a[0] : in_b[1];
        opr_next[7] = is_cross ? in_b[2] : in_b[1];
        opl_next[8] = is_cross ? in_a[1] : in_b[2];
        opr_next[8] = is_cross ? in_b[0] : in_b[2];
    end

    // ---- stage 1: products; stage 2: sums -------------------------------
    logic signed [PW-1:0]   prod_next [vfa_pkg::NMUL];
    logic signed [PW-1:0]   prod_reg  [vfa_pkg::NMUL];
    logic signed [WW-1:0]   dsum_reg;
    logic [PW-1:0]          sqa_reg, sqb_reg, sqa3_reg, sqb3_reg;
    logic signed [PW:0]     crs_reg [3];
    logic signed [PW-1:0]   scl_reg [3];

    always_comb
    begin
        for (int j = 0; j < vfa_pkg::NMUL; j++)
            prod_next[j] = opl_reg[j] * opr_reg[j];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd0_reg <= in_cmd;
            cmd1_reg <= cmd0_reg;
            cmd2_reg <= cmd1_reg;
            for (int j = 0; j < vfa_pkg::NMUL; j++)
            begin
                opl_reg[j]  <= opl_next[j];
                opr_reg[j]  <= opr_next[j];
                prod_reg[j] <= prod_next[j];
            end
            for (int i = 0; i < 3; i++)
            begin
                a0_reg[i]  <= in_a[i];
                b0_reg[i]  <= in_b[i];
                a1_reg[i]  <= a0_reg[i];
                b1_reg[i]  <= b0_reg[i];
                a2_reg[i]  <= a1_reg[i];
                b2_reg[i]  <= b1_reg[i];
                crs_reg[i] <= (PW+1)'(prod_reg[3+i]) - (PW+1)'(prod_reg[6+i]);
                scl_reg[i] <= prod_reg[i];
            end
            dsum_reg <= WW'(prod_reg[0]) + WW'(prod_reg[1]) + WW'(prod_reg[2]);
            sqa_reg  <= prod_reg[3] + prod_reg[4] + prod_reg[5];
            sqb_reg  <= prod_reg[6] + prod_reg[7] + prod_reg[8];
            sqa3_reg <= sqa_reg;
            sqb3_reg <= sqb_reg;
        end
    end

    // ---- stage 3: early results, dividends ------------------------------
    vfa_pkg::side_t side_next, side3_reg;

    always_comb
    begin
        logic signed [WW-1:0] cand;
        logic signed [WW-1:0] dotv;
        logic [WW-1:0]        dmag;
        logic signed [DW:0]   dif;
        logic [DW:0]          dabs;
        logic [DW-1:0]        absa;
        logic [2:0]           in_tol;
        logic                 flt;
        vfa_pkg::sat_t        sv;
        side_next     = '0;
        side_next.cmd = cmd2_reg;
        flt           = 1'b0;
        dmag          = '0;
        for (int i = 0; i < 3; i++)
        begin
            unique case (cmd2_reg)
                vfa_pkg::CMD_ADD:   cand = WW'(a2_reg[i]) + WW'(b2_reg[i]);
                vfa_pkg::CMD_SUB:   cand = WW'(a2_reg[i]) - WW'(b2_reg[i]);
                vfa_pkg::CMD_SCALE: cand = WW'(scl_reg[i] >>> FB);
                vfa_pkg::CMD_CROSS: cand = WW'(crs_reg[i] >>> FB);
                default:            cand = '0;
            endcase
            sv               = vfa_pkg::sat_wide(cand);
            side_next.ev[i]  = sv.val;
            flt              = flt | sv.flt;
            absa             = a2_reg[i][DW-1] ? DW'(-a2_reg[i]) : a2_reg[i];
            side_next.neg[i] = a2_reg[i][DW-1];
            side_next.num[i] = PW'(absa) << FB;
            dif              = (DW+1)'(a2_reg[i]) - (DW+1)'(b2_reg[i]);
            dabs             = dif[DW] ? (DW+1)'(-dif) : dif;
            in_tol[i]        = dabs < (DW+1)'(eps_reg);
        end
        dotv = dsum_reg >>> FB;
        if (cmd2_reg == vfa_pkg::CMD_DOT)
        begin
            sv            = vfa_pkg::sat_wide(dotv);
            side_next.esc = sv.val;
            flt           = flt | sv.flt;
        end
        if (cmd2_reg == vfa_pkg::CMD_COS)
        begin
            side_next.dneg   = dotv[WW-1];
            dmag             = dotv[WW-1] ? WW'(-dotv) : dotv;
            side_next.num[0] = PW'(dmag) << FB;
        end
        side_next.eq   = (cmd2_reg == vfa_pkg::CMD_CMP) && (&in_tol);
        side_next.eflt = flt;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            side3_reg <= side_next;
    end

    // ---- square roots of |A|^2 and |B|^2 --------------------------------
    logic            sq_valid;
    vfa_pkg::side_t  sq_side;
    logic [DW-1:0]   sq_len_a, sq_len_b;

    vfa_sqrt_pipe u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v3_reg),
        .in_side   (side3_reg),
        .in_a      (sqa3_reg),
        .in_b      (sqb3_reg),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .out_len_a (sq_len_a),
        .out_len_b (sq_len_b)
    );

    // ---- stage 4: length product ----------------------------------------
    logic [PW-1:0]  lprod_next, lprod4_reg;
    logic [DW-1:0]  lena4_reg;
    vfa_pkg::side_t side4_reg;

    assign lprod_next = sq_len_a * sq_len_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (adv)
            v4_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side4_reg  <= sq_side;
            lena4_reg  <= sq_len_a;
            lprod4_reg <= lprod_next;
        end
    end

    // ---- divider feed ----------------------------------------------------
    logic [vfa_pkg::DIV_DW-1:0]       cos_p;
    logic [2:0][vfa_pkg::DIV_DW-1:0]  dv_den;
    vfa_pkg::side_t                   dv_side_in;

    always_comb
    begin
        cos_p             = lprod4_reg[PW-1:FB];
        dv_side_in        = side4_reg;
        dv_side_in.len_a  = lena4_reg;
        dv_side_in.p_zero = (cos_p == '0);
        dv_den[0] = (side4_reg.cmd == vfa_pkg::CMD_COS) ? cos_p
                                                        : vfa_pkg::DIV_DW'(lena4_reg);
        dv_den[1] = vfa_pkg::DIV_DW'(lena4_reg);
        dv_den[2] = vfa_pkg::DIV_DW'(lena4_reg);
    end

    logic                      dv_valid;
    vfa_pkg::side_t            dv_side;
    logic [2:0][PW-1:0]        dv_quo;

    vfa_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v4_reg),
        .in_side   (dv_side_in),
        .in_num    (side4_reg.num),
        .in_den    (dv_den),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .out_quo   (dv_quo)
    );

    // ---- result stage ----------------------------------------------------
    logic [2:0][DW-1:0] ov_next, ov_reg;
    logic [DW-1:0]      osc_next, osc_reg;
    logic               oeq_next, oeq_reg;
    logic               oflt_next, oflt_reg;
    logic [CMD_W-1:0]   ocmd_reg;
    logic               opz_reg;

    always_comb
    begin
        vfa_pkg::sat_t sv;
        sv        = '0;
        ov_next   = dv_side.ev;
        osc_next  = dv_side.esc;
        oeq_next  = dv_side.eq;
        oflt_next = dv_side.eflt;
        unique case (dv_side.cmd)
            vfa_pkg::CMD_LEN:
            begin
                sv        = vfa_pkg::signed_mag(1'b0, PW'(dv_side.len_a));
                osc_next  = sv.val;
                oflt_next = sv.flt;
            end
            vfa_pkg::CMD_NORM:
            begin
                // zero-length A leaves the zero vector, no fault
                if (dv_side.len_a != '0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        sv         = vfa_pkg::signed_mag(dv_side.neg[i], dv_quo[i]);
                        ov_next[i] = sv.val;
                        oflt_next  = oflt_next | sv.flt;
                    end
                end
            end
            vfa_pkg::CMD_COS:
            begin
                if (dv_side.p_zero)
                begin
                    osc_next  = '0;
                    oflt_next = 1'b1;
                end
                else
                begin
                    sv        = vfa_pkg::signed_mag(dv_side.dneg, dv_quo[0]);
                    osc_next  = sv.val;
                    oflt_next = sv.flt;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vout_reg <= 1'b0;
        else if (adv)
            vout_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ov_reg   <= ov_next;
            osc_reg  <= osc_next;
            oeq_reg  <= oeq_next;
            oflt_reg <= oflt_next;
            ocmd_reg <= dv_side.cmd;
            opz_reg  <= dv_side.p_zero;
        end
    end

    assign m_tvalid = vout_reg;
    assign m_tdata  = OUT_W'({oflt_reg, oeq_reg, osc_reg, ov_reg[2], ov_reg[1], ov_reg[0]});

    // ---- checks ------------------------------------------------------------
    a_cos_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
        vout_reg && ocmd_reg == vfa_pkg::CMD_COS && opz_reg
        |-> oflt_reg && osc_reg == '0)
        else $error("cosine with zero denominator not faulted");

    a_eq_only_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        vout_reg && ocmd_reg != vfa_pkg::CMD_CMP |-> !oeq_reg)
        else $error("is_equal set outside compare");

    a_scalar_cmd_no_vec: assert property (@(posedge clk) disable iff (!rst_n)
        vout_reg && (ocmd_reg == vfa_pkg::CMD_DOT || ocmd_reg == vfa_pkg::CMD_LEN ||
                     ocmd_reg == vfa_pkg::CMD_COS || ocmd_reg == vfa_pkg::CMD_CMP)
        |-> ov_reg == '0)
        else $error("vector result on a scalar command");

    a_len_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        vout_reg && ocmd_reg == vfa_pkg::CMD_LEN |-> !osc_reg[DW-1])
        else $error("negative length");

endmodule

/* src/vfa_sqrt_pipe.sv */
// Two-lane pipelined integer square root, one root bit per stage.
// Depends on vfa_pkg; carries a side_t tag through every stage with the roots.
module vfa_sqrt_pipe (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  vfa_pkg::side_t              in_side,
    input  logic [vfa_pkg::PW-1:0]      in_a,
    input  logic [vfa_pkg::PW-1:0]      in_b,
    output logic                        out_valid,
    output vfa_pkg::side_t              out_side,
    output logic [vfa_pkg::DW-1:0]      out_len_a,
    output logic [vfa_pkg::DW-1:0]      out_len_b
);

    vfa_pkg::sq_t   a_reg    [vfa_pkg::SQ_STEPS];
    vfa_pkg::sq_t   a_next   [vfa_pkg::SQ_STEPS];
    vfa_pkg::sq_t   b_reg    [vfa_pkg::SQ_STEPS];
    vfa_pkg::sq_t   b_next   [vfa_pkg::SQ_STEPS];
    vfa_pkg::side_t side_reg [vfa_pkg::SQ_STEPS];
    logic [vfa_pkg::SQ_STEPS-1:0] vld_reg;

    genvar k;
    generate
        for (k = 0; k < vfa_pkg::SQ_STEPS; k++)
        begin : g_stage
            if (k == 0)
            begin : g_first
                always_comb
                begin
                    a_next[k] = vfa_pkg::sqrt_step(vfa_pkg::sq_t'{n: in_a, r: '0}, k);
                    b_next[k] = vfa_pkg::sqrt_step(vfa_pkg::sq_t'{n: in_b, r: '0}, k);
                end
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                        vld_reg[k] <= 1'b0;
                    else if (en)
                        vld_reg[k] <= in_valid;
                end
                always_ff @(posedge clk)
                begin
                    if (en)
                        side_reg[k] <= in_side;
                end
            end
            else
            begin : g_rest
                always_comb
                begin
                    a_next[k] = vfa_pkg::sqrt_step(a_reg[k-1], k);
                    b_next[k] = vfa_pkg::sqrt_step(b_reg[k-1], k);
                end
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                        vld_reg[k] <= 1'b0;
                    else if (en)
                        vld_reg[k] <= vld_reg[k-1];
                end
                always_ff @(posedge clk)
                begin
                    if (en)
                        side_reg[k] <= side_reg[k-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    a_reg[k] <= a_next[k];
                    b_reg[k] <= b_next[k];
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[vfa_pkg::SQ_STEPS-1];
    assign out_side  = side_reg[vfa_pkg::SQ_STEPS-1];
    assign out_len_a = a_reg[vfa_pkg::SQ_STEPS-1].r[vfa_pkg::DW-1:0];
    assign out_len_b = b_reg[vfa_pkg::SQ_STEPS-1].r[vfa_pkg::DW-1:0];

endmodule

/* src/vfa_div_pipe.sv */
// Three-lane pipelined restoring divider, one quotient bit per stage.
// Depends on vfa_pkg; carries a side_t tag through every stage with the quotients.
module vfa_div_pipe (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  vfa_pkg::side_t                         in_side,
    input  logic [2:0][vfa_pkg::PW-1:0]            in_num,
    input  logic [2:0][vfa_pkg::DIV_DW-1:0]        in_den,
    output logic                                   out_valid,
    output vfa_pkg::side_t                         out_side,
    output logic [2:0][vfa_pkg::PW-1:0]            out_quo
);

    vfa_pkg::div_t  ln_reg   [vfa_pkg::DIV_STEPS][3];
    vfa_pkg::div_t  ln_next  [vfa_pkg::DIV_STEPS][3];
    vfa_pkg::side_t side_reg [vfa_pkg::DIV_STEPS];
    logic [vfa_pkg::DIV_STEPS-1:0] vld_reg;

    genvar k;
    generate
        for (k = 0; k < vfa_pkg::DIV_STEPS; k++)
        begin : g_stage
            if (k == 0)
            begin : g_first
                always_comb
                begin
                    for (int l = 0; l < 3; l++)
                        ln_next[k][l] = vfa_pkg::div_step(vfa_pkg::div_t'{
                            rem: '0, num: in_num[l], q: '0, d: in_den[l]});
                end
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                        vld_reg[k] <= 1'b0;
                    else if (en)
                        vld_reg[k] <= in_valid;
                end
                always_ff @(posedge clk)
                begin
                    if (en)
                        side_reg[k] <= in_side;
                end
            end
            else
            begin : g_rest
                always_comb
                begin
                    for (int l = 0; l < 3; l++)
                        ln_next[k][l] = vfa_pkg::div_step(ln_reg[k-1][l]);
                end
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                        vld_reg[k] <= 1'b0;
                    else if (en)
                        vld_reg[k] <= vld_reg[k-1];
                end
                always_ff @(posedge clk)
                begin
                    if (en)
                        side_reg[k] <= side_reg[k-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    for (int l = 0; l < 3; l++)
                        ln_reg[k][l] <= ln_next[k][l];
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[vfa_pkg::DIV_STEPS-1];
    assign out_side  = side_reg[vfa_pkg::DIV_STEPS-1];

    always_comb
    begin
        for (int l = 0; l < 3; l++)
            out_quo[l] = ln_reg[vfa_pkg::DIV_STEPS-1][l].q;
    end

endmodule
